[hw/rtl/spq_pkg.sv]
`default_nettype none

package spq_pkg;

  localparam int TAG_W   = 16;
  localparam int PRIO_W  = 16;
  localparam int CNT_W   = 5;
  localparam int ERR_W   = 2;

  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  localparam logic [ERR_W-1:0] ERR_OK    = 2'd0;
  localparam logic [ERR_W-1:0] ERR_FULL  = 2'd1;
  localparam logic [ERR_W-1:0] ERR_EMPTY = 2'd2;

  typedef struct packed {
    logic [TAG_W-1:0]  tag;
    logic [PRIO_W-1:0] prio;
  } entry_t;

  // broadcast to every cell of the chain
  typedef struct packed {
    logic   enq;
    logic   deq;
    entry_t new_ent;
  } ctrl_t;

endpackage

`default_nettype wire

[hw/rtl/stable_sorted_priority_queue.sv]
// Latency: the result of a transaction is presented in the cycle after it is accepted.
// Throughput: one enqueue or dequeue per cycle unless a result waits; every cell
//   of the sorted chain compares against the new entry and shifts one place at once.
// Reset: synchronous rst empties the queue (count to zero) and drops any pending
//   result; stored entries are not cleared and are never shown before written.
`default_nettype none

module stable_sorted_priority_queue #(
  parameter int DEPTH = 16
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic                       op,
  input  wire logic [spq_pkg::TAG_W-1:0]  item_tag,
  input  wire logic [spq_pkg::PRIO_W-1:0] item_priority,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [spq_pkg::TAG_W-1:0]       front_tag,
  output logic [spq_pkg::PRIO_W-1:0]      front_priority,
  output logic [spq_pkg::CNT_W-1:0]       entry_count,
  output logic                            is_empty,
  output logic [spq_pkg::ERR_W-1:0]       error_code
);
  import spq_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  logic [CW-1:0]      count;
  logic [CW-1:0]      count_next;
  logic [ERR_W-1:0]   err;
  logic [ERR_W-1:0]   err_next;
  logic               in_fire;
  logic               full;
  logic               empty;
  ctrl_t              ctrl;
  entry_t             ents  [DEPTH];
  logic               keeps [DEPTH];
  logic [CW+CNT_W-1:0] count_ext;

  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;
  assign full     = count == CW'(DEPTH);
  assign empty    = count == '0;

  assign ctrl.enq         = in_fire && (op == OP_ENQ) && !full;
  assign ctrl.deq         = in_fire && (op == OP_DEQ) && !empty;
  assign ctrl.new_ent.tag  = item_tag;
  assign ctrl.new_ent.prio = item_priority;

  always_comb begin
    count_next = count;
    err_next   = ERR_OK;
    if (op == OP_ENQ) begin
      if (full) err_next = ERR_FULL;
      else count_next = count + CW'(1);
    end else begin
      if (empty) err_next = ERR_EMPTY;
      else count_next = count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else if (in_fire) begin
      count     <= count_next;
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      err <= err_next;
    end
  end

  genvar i;
  generate
    for (i = 0; i < DEPTH; i++) begin : g_cell
      entry_t l_ent;
      entry_t r_ent;
      logic   l_keep;

      if (i == 0) begin : g_head
        assign l_ent  = ctrl.new_ent;
        assign l_keep = 1'b1;
      end else begin : g_body
        assign l_ent  = ents[i-1];
        assign l_keep = keeps[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
        assign r_ent = ents[i];
      end else begin : g_mid
        assign r_ent = ents[i+1];
      end

      spq_cell #(
        .DEPTH (DEPTH),
        .IDX   (i),
        .CW    (CW)
      ) u_cell (
        .clk       (clk),
        .ctrl      (ctrl),
        .count     (count),
        .left_keep (l_keep),
        .left_ent  (l_ent),
        .right_ent (r_ent),
        .ent       (ents[i]),
        .keep      (keeps[i])
      );
    end
  endgenerate

  // results follow the live state; it only moves when no result is pending or it is taken
  assign count_ext      = {{CNT_W{1'b0}}, count};
  assign entry_count    = count_ext[CNT_W-1:0];
  assign is_empty       = empty;
  assign front_tag      = empty ? '0 : ents[0].tag;
  assign front_priority = empty ? '0 : ents[0].prio;
  assign error_code     = err;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("entry count exceeds depth");

  a_enq_grow: assert property (@(posedge clk) disable iff (rst)
    ctrl.enq |=> count == $past(count) + CW'(1))
    else $error("enqueue did not grow count");

  a_deq_shrink: assert property (@(posedge clk) disable iff (rst)
    ctrl.deq |=> count == $past(count) - CW'(1))
    else $error("dequeue did not shrink count");

  a_err_hold: assert property (@(posedge clk) disable iff (rst)
    in_fire && (full && op == OP_ENQ || empty && op == OP_DEQ) |=> $stable(count))
    else $error("rejected transaction changed count");

  a_sorted_head: assert property (@(posedge clk) disable iff (rst)
    count >= CW'(2) |-> ents[0].prio >= ents[1].prio)
    else $error("front pair out of order");

endmodule

`default_nettype wire

[hw/rtl/spq_cell.sv]
`default_nettype none

module spq_cell #(
  parameter int DEPTH = 16,
  parameter int IDX   = 0,
  parameter int CW    = $clog2(DEPTH + 1)
) (
  input  wire logic            clk,
  input  wire spq_pkg::ctrl_t  ctrl,
  input  wire logic [CW-1:0]   count,
  input  wire logic            left_keep,
  input  wire spq_pkg::entry_t left_ent,
  input  wire spq_pkg::entry_t right_ent,
  output spq_pkg::entry_t      ent,
  output logic                 keep
);
  import spq_pkg::*;

  logic live;

  assign live = CW'(IDX) < count;
  // entries ahead of the insertion point stay put; ties stay ahead of the new one
  assign keep = live && (ent.prio >= ctrl.new_ent.prio);

  always_ff @(posedge clk) begin
    if (ctrl.enq) begin
      if (!keep) begin
        ent <= left_keep ? ctrl.new_ent : left_ent;
      end
    end else if (ctrl.deq) begin
      ent <= right_ent;
    end
  end

endmodule

`default_nettype wire
